### hdl/lcs_pkg.sv
// Shared types, constants and the division step for the linear contrast stretch unit.
// Used by lcs_div_stage and linear_contrast_stretch_unit; depends on nothing else.
`default_nettype none
package lcs_pkg;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned NUM_W      = 2 * PIX_W;
    localparam int unsigned DVD_W      = NUM_W + 1;
    localparam int unsigned QUO_W      = PIX_W + 1;
    localparam int unsigned DIV_STAGES = 3;
    localparam int unsigned STEP_PER_STAGE = QUO_W / DIV_STAGES;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [1:0] {
        REG_IN_LOW   = 2'd0,
        REG_IN_HIGH  = 2'd1,
        REG_OUT_LOW  = 2'd2,
        REG_OUT_HIGH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             interior;
        logic [PIX_W-1:0] bypass;
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] quot;
        logic [QUO_W-1:0] dvd;
        logic [QUO_W-1:0] dvs;
    } t_div;

    function automatic t_div div_step(input t_div s);
        t_div            r;
        logic [QUO_W:0]  trial;
        r     = s;
        trial = {s.rem, s.dvd[QUO_W-1]};
        if (trial >= {1'b0, s.dvs}) begin
            r.rem  = QUO_W'(trial - {1'b0, s.dvs});
            r.quot = {s.quot[QUO_W-2:0], 1'b1};
        end else begin
            r.rem  = trial[QUO_W-1:0];
            r.quot = {s.quot[QUO_W-2:0], 1'b0};
        end
        r.dvd = {s.dvd[QUO_W-2:0], 1'b0};
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/lcs_div_stage.sv
// One registered slice of the restoring divider: three quotient bits per cycle.
// Depends on lcs_pkg for the word type and the step function.
`default_nettype none
module lcs_div_stage
    import lcs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_div i_data,
    output logic      o_valid,
    output t_div      o_data
);

    t_div n_data;
    logic r_valid;
    t_div r_data;

    always_comb begin
        n_data = i_data;
        for (int i = 0; i < STEP_PER_STAGE; i++) begin
            n_data = div_step(n_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
`default_nettype wire

### hdl/linear_contrast_stretch_unit.sv
// Linear contrast stretch of 8-bit gray pixels, six register stages deep.
// Throughput: one word per cycle; busy is never raised and the receiver cannot stall.
// Reset (synchronous, active low) clears the pipeline valid bits and restores
// the bounds to in 0..255 and out 0..255. Depends on lcs_pkg and lcs_div_stage.
`default_nettype none
module linear_contrast_stretch_unit
    import lcs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [PIX_W-1:0] i_pixel_in,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [PIX_W-1:0] i_cfg_wdata,
    output logic                  o_strobe,
    output logic [PIX_W-1:0]      o_pixel_out
);

    logic [PIX_W-1:0] r_in_low;
    logic [PIX_W-1:0] r_in_high;
    logic [PIX_W-1:0] r_out_low;
    logic [PIX_W-1:0] r_out_high;

    logic             accept;
    logic             n_interior;
    logic [PIX_W-1:0] n_bypass;

    logic             r_v1;
    logic             r_int1;
    logic [PIX_W-1:0] r_byp1;
    logic [PIX_W-1:0] r_n1;
    logic [PIX_W-1:0] r_dn1;
    logic [PIX_W-1:0] r_d1;
    logic [PIX_W-1:0] r_olo1;
    logic [PIX_W-1:0] r_ohi1;

    logic [NUM_W-1:0] num2;
    logic [DVD_W-1:0] dividend2;
    logic             r_v2;
    t_div             r_s2;

    logic             v3;
    t_div             s3;
    logic             v4;
    t_div             s4;
    logic             v5;
    t_div             s5;

    logic             r_strobe;
    logic [PIX_W-1:0] r_pixel_out;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_low   <= '0;
            r_in_high  <= PIX_MAX;
            r_out_low  <= '0;
            r_out_high <= PIX_MAX;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_IN_LOW:   r_in_low   <= i_cfg_wdata;
                REG_IN_HIGH:  r_in_high  <= i_cfg_wdata;
                REG_OUT_LOW:  r_out_low  <= i_cfg_wdata;
                REG_OUT_HIGH: r_out_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_interior = 1'b0;
        n_bypass   = r_out_high;
        if (r_in_low == r_out_low && r_in_high == r_out_high) begin
            n_bypass = i_pixel_in;
        end else if (r_in_low == r_in_high) begin
            n_bypass = r_out_high;
        end else if (i_pixel_in <= r_in_low) begin
            n_bypass = r_out_low;
        end else if (i_pixel_in >= r_in_high) begin
            n_bypass = r_out_high;
        end else begin
            n_interior = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_int1 <= n_interior;
        r_byp1 <= n_bypass;
        r_n1   <= i_pixel_in - r_in_low;
        r_d1   <= r_in_high - r_in_low;
        r_dn1  <= r_in_high - i_pixel_in;
        r_olo1 <= r_out_low;
        r_ohi1 <= r_out_high;
    end

    assign num2      = NUM_W'(r_olo1) * NUM_W'(r_dn1) + NUM_W'(r_ohi1) * NUM_W'(r_n1);
    assign dividend2 = {num2, 1'b0} + DVD_W'(r_d1);

    always_ff @(posedge i_clk) begin
        r_s2.interior <= r_int1;
        r_s2.bypass   <= r_byp1;
        r_s2.rem      <= {1'b0, dividend2[DVD_W-1:QUO_W]};
        r_s2.quot     <= '0;
        r_s2.dvd      <= dividend2[QUO_W-1:0];
        r_s2.dvs      <= {r_d1, 1'b0};
    end

    lcs_div_stage u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_data  (r_s2),
        .o_valid (v3),
        .o_data  (s3)
    );

    lcs_div_stage u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v3),
        .i_data  (s3),
        .o_valid (v4),
        .o_data  (s4)
    );

    lcs_div_stage u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v4),
        .i_data  (s4),
        .o_valid (v5),
        .o_data  (s5)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s5.interior) begin
            r_pixel_out <= s5.bypass;
        end else if (s5.quot[QUO_W-1]) begin
            r_pixel_out <= PIX_MAX;
        end else begin
            r_pixel_out <= s5.quot[PIX_W-1:0];
        end
    end

    assign o_strobe    = r_strobe;
    assign o_pixel_out = r_pixel_out;

`ifndef SYNTHESIS
    a_strobe_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 6))
        else $error("Output word without a matching start six edges earlier.");

    a_interior_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_int1) |-> (r_n1 != '0 && r_n1 < r_d1))
        else $error("Interior pixel offset outside the input range.");

    a_quotient_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v5 && s5.interior) |-> (s5.quot[QUO_W-1] == 1'b0 && s5.rem < s5.dvs))
        else $error("Divider result out of range for an interior pixel.");
`endif

endmodule
`default_nettype wire
